[rtl/bhdsha_pkg.sv]
// ----------------------------------------------------------------------------
// bhdsha_pkg: shared constants and functions for the header double SHA-256
// Round constants, initial hash values, padding words and the SHA-256
// sigma functions used by the round unit and the message schedule.
// ----------------------------------------------------------------------------
package bhdsha_pkg;

  localparam int unsigned HDR_BYTES    = 128;
  localparam int unsigned DIGEST_BYTES = 32;

  localparam logic [31:0] HDR_BITS    = 32'(HDR_BYTES * 8);
  localparam logic [31:0] DIGEST_BITS = 32'(DIGEST_BYTES * 8);
  localparam logic [31:0] PAD_WORD    = 32'h8000_0000;

  typedef logic [31:0] word_t;

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t swap32(input word_t x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t sml_sig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t sml_sig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

[rtl/block_header_double_sha256_top.sv]
// ----------------------------------------------------------------------------
// block_header_double_sha256_top: double SHA-256 of a 128-byte header
// Collects sixteen 64-bit header chunks, hashes them with one shared
// SHA-256 round unit and returns the second digest as a big-endian number.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_ready / in_header_chunk) takes one beat
// per eight header bytes, lowest-offset byte in bits 7:0. Sixteen beats make
// one header. The result channel (out_valid / out_ready / out_hash_q0..q3)
// carries one beat per header: the second digest read as a big-endian
// 256-bit number, with H0:H1 on q3 and H6:H7 on q0.
// Beats that do not close a 64-byte block leave in_ready high. The eighth
// beat starts a compression, the rounds and then the chaining add, during
// which in_ready is low. The sixteenth beat runs three compressions back
// to back (second header block, padding block and the second hash), after
// which the result beat is raised. Throughput is set by the single round
// unit doing one SHA-256 round a cycle; in_ready stays low while it runs.
// The result sits in an output register, so chunks of the next header are
// accepted while it waits; only if a new result is ready before the old one
// is taken does the block hold in its final add step until out_ready.
// A synchronous active-low reset empties the chunk counter, drops out_valid
// and loads the chaining value with the SHA-256 initial hash.
// ----------------------------------------------------------------------------
module block_header_double_sha256_top
  import bhdsha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_header_chunk,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hash_q0,
  output logic [63:0] out_hash_q1,
  output logic [63:0] out_hash_q2,
  output logic [63:0] out_hash_q3
);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  // Which 64-byte block the round unit is working on.
  localparam logic [1:0] PH_HDR0   = 2'd0;
  localparam logic [1:0] PH_HDR1   = 2'd1;
  localparam logic [1:0] PH_PAD    = 2'd2;
  localparam logic [1:0] PH_SECOND = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [3:0]  count_r, count_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] q0_r, q0_nxt, q1_r, q1_nxt, q2_r, q2_nxt, q3_r, q3_nxt;

  // The sixteen-word schedule window doubles as the message buffer: chunks
  // land in it byte-swapped, and it shifts one word per round.
  word_t w_r     [16];
  word_t w_nxt   [16];
  word_t work_r  [8];
  word_t work_nxt[8];
  word_t chain_r [8];
  word_t chain_nxt[8];
  word_t sum     [8];

  logic  in_acc;
  logic  out_free;
  word_t t1, t2, new_w;
  logic [2:0] slot;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign slot     = count_r[2:0];

  // One SHA-256 round and one schedule step.
  always_comb begin
    t1 = work_r[7] + big_sig1(work_r[4])
       + ((work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]))
       + ROUND_K[rnd_r] + w_r[0];
    t2 = big_sig0(work_r[0])
       + ((work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]));
    new_w = w_r[0] + sml_sig0(w_r[1]) + w_r[9] + sml_sig1(w_r[14]);
    // The second hash starts from the initial values, not the chain.
    for (int i = 0; i < 8; i++) begin
      sum[i] = ((phase_r == PH_SECOND) ? INIT_H[i] : chain_r[i]) + work_r[i];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    rnd_nxt       = rnd_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    q0_nxt        = q0_r;
    q1_nxt        = q1_r;
    q2_nxt        = q2_r;
    q3_nxt        = q3_r;
    w_nxt         = w_r;
    work_nxt      = work_r;
    chain_nxt     = chain_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          w_nxt[{slot, 1'b0}] = swap32(in_header_chunk[31:0]);
          w_nxt[{slot, 1'b1}] = swap32(in_header_chunk[63:32]);
          count_nxt = count_r + 4'd1;
          if (slot == 3'd7) begin
            // A full 64-byte block is in the window: compress it.
            state_nxt = ST_ROUND;
            phase_nxt = count_r[3] ? PH_HDR1 : PH_HDR0;
            rnd_nxt   = '0;
            work_nxt  = chain_r;
          end
        end
      end
      ST_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i + 1];
        end
        w_nxt[15]   = new_w;
        work_nxt[0] = t1 + t2;
        work_nxt[1] = work_r[0];
        work_nxt[2] = work_r[1];
        work_nxt[3] = work_r[2];
        work_nxt[4] = work_r[3] + t1;
        work_nxt[5] = work_r[4];
        work_nxt[6] = work_r[5];
        work_nxt[7] = work_r[6];
        rnd_nxt     = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        case (phase_r)
          PH_HDR0: begin
            chain_nxt = sum;
            state_nxt = ST_IDLE;
          end
          PH_HDR1: begin
            // Padding block of the first pass.
            chain_nxt = sum;
            work_nxt  = sum;
            for (int i = 0; i < 16; i++) begin
              w_nxt[i] = '0;
            end
            w_nxt[0]  = PAD_WORD;
            w_nxt[15] = HDR_BITS;
            phase_nxt = PH_PAD;
            rnd_nxt   = '0;
            state_nxt = ST_ROUND;
          end
          PH_PAD: begin
            // Second pass over the 32-byte first digest.
            chain_nxt = sum;
            work_nxt  = INIT_H;
            for (int i = 0; i < 8; i++) begin
              w_nxt[i]     = sum[i];
              w_nxt[i + 8] = '0;
            end
            w_nxt[8]  = PAD_WORD;
            w_nxt[15] = DIGEST_BITS;
            phase_nxt = PH_SECOND;
            rnd_nxt   = '0;
            state_nxt = ST_ROUND;
          end
          default: begin
            // Hold here until the output register is free.
            if (out_free) begin
              q3_nxt        = {sum[0], sum[1]};
              q2_nxt        = {sum[2], sum[3]};
              q1_nxt        = {sum[4], sum[5]};
              q0_nxt        = {sum[6], sum[7]};
              out_valid_nxt = 1'b1;
              chain_nxt     = INIT_H;
              state_nxt     = ST_IDLE;
            end
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_HDR0;
      rnd_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      chain_r     <= INIT_H;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      rnd_r       <= rnd_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      chain_r     <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r    <= w_nxt;
    work_r <= work_nxt;
    q0_r   <= q0_nxt;
    q1_r   <= q1_nxt;
    q2_r   <= q2_nxt;
    q3_r   <= q3_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_hash_q0 = q0_r;
  assign out_hash_q1 = q1_r;
  assign out_hash_q2 = q2_r;
  assign out_hash_q3 = q3_r;

  // The sixteenth chunk must start the second header block.
  a_last_chunk_starts_hdr1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (count_r == 4'd15) |=> (state_r == ST_ROUND) && (phase_r == PH_HDR1))
    else $error("last chunk did not start the second header block");

  // Rounds run only on a complete block.
  a_round_on_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (count_r[2:0] == 3'd0))
    else $error("compression running on a partial block");

  // Sixty-four rounds end in the chaining add.
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) && (rnd_r == 6'd63) |=> (state_r == ST_FINAL))
    else $error("round counter did not hand over to the final add");

  // A result appears only out of the final add of the second hash.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FINAL) && ($past(phase_r) == PH_SECOND))
    else $error("result raised outside the second hash");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for block_header_double_sha256_top
// Streams 64-bit header chunks into the hasher and checks every digest beat
// against a bit-exact double SHA-256 predictor that runs beside the design.
// Both channels idle at random, and a watchdog ends a run that hangs.
// ----------------------------------------------------------------------------
module tb_top;

  // SHA-256 round constants, first entry at index 0.
  localparam logic [0:63][31:0] SHA_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // SHA-256 initial hash value, H0 at index 0.
  localparam logic [0:7][31:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] PAD_MARK        = 32'h8000_0000;
  localparam logic [31:0] HEADER_LEN_BITS = 32'd1024;
  localparam logic [31:0] DIGEST_LEN_BITS = 32'd256;

  localparam int RANDOM_CHUNKS  = 700;
  localparam int WATCHDOG_LIMIT = 4000;
  // Quiet cycles after the last digest: covers one full header worth of work.
  localparam int DRAIN_CYCLES   = 300;

  // Directed chunks: one complete header of field extremes and bit patterns,
  // then the first half of a second header so that the random stream carries
  // on mid-header. A SHA-256 digest cannot be read off by eye, so every beat
  // here is checked against the predictor rather than a typed-in value.
  localparam int DIRECTED_ROWS = 24;
  localparam logic [0:DIRECTED_ROWS-1][63:0] DIRECTED_CHUNKS = {
    64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff,
    64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
    64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000,
    64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
    // Second 64-byte block; reserved-looking bytes are nonzero on purpose.
    64'hffff_ffff_0000_0000, 64'h0000_0000_ffff_ffff,
    64'h00ff_00ff_00ff_00ff, 64'hff00_ff00_ff00_ff00,
    64'h8000_0000_0000_0001, 64'h7fff_ffff_ffff_fffe,
    64'hdead_beef_cafe_f00d, 64'hffff_ffff_ffff_ffff,
    // Second header, first block only.
    64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
    64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0f0f_0f0f_0f0f_0f0f, 64'hf0f0_f0f0_f0f0_f0f0,
    64'h3333_3333_3333_3333, 64'hcccc_cccc_cccc_cccc
  };

  typedef logic [0:7][31:0]  hash_state_t;
  typedef logic [0:15][31:0] msg_block_t;

  typedef struct packed {
    logic [63:0] q3;
    logic [63:0] q2;
    logic [63:0] q1;
    logic [63:0] q0;
  } digest_t;

  // Receiver behavior, picked anew at the end of each stretch.
  typedef enum logic [1:0] {
    RDY_OPEN,
    RDY_CHOPPY,
    RDY_HELD
  } ready_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_header_chunk;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_hash_q0;
  logic [63:0] out_hash_q1;
  logic [63:0] out_hash_q2;
  logic [63:0] out_hash_q3;

  // Predictor state: running first-pass hash, the current 64-byte block and
  // the position inside the 128-byte header.
  hash_state_t       chain_hash;
  logic [0:7][63:0]  block_chunks;
  logic [3:0]        header_pos;
  digest_t           pending_digests[$];

  int          fail_count;
  int          idle_cycles;
  int          burst_left;
  int          ready_left;
  ready_mode_t ready_mode;
  digest_t     oldest_digest;

  block_header_double_sha256_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_header_chunk (in_header_chunk),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hash_q0     (out_hash_q0),
    .out_hash_q1     (out_hash_q1),
    .out_hash_q2     (out_hash_q2),
    .out_hash_q3     (out_hash_q3)
  );

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------
  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] byte_rev(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  // One SHA-256 compression: 64 rounds plus the feed-forward add.
  function automatic hash_state_t sha_compress(input hash_state_t hin,
                                               input msg_block_t blk);
    logic [0:63][31:0] w;
    logic [31:0] a, b, c, d, e, f, g, hv, t1, t2, s0, s1;
    hash_state_t hout;
    int i;
    for (i = 0; i < 16; i++) begin
      w[i] = blk[i];
    end
    for (i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = hin[0]; b = hin[1]; c = hin[2]; d = hin[3];
    e = hin[4]; f = hin[5]; g = hin[6]; hv = hin[7];
    for (i = 0; i < 64; i++) begin
      t1 = hv + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + SHA_K[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      hv = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hout[0] = hin[0] + a; hout[1] = hin[1] + b;
    hout[2] = hin[2] + c; hout[3] = hin[3] + d;
    hout[4] = hin[4] + e; hout[5] = hin[5] + f;
    hout[6] = hin[6] + g; hout[7] = hin[7] + hv;
    return hout;
  endfunction

  // Takes one accepted chunk. The eighth and sixteenth chunks close a
  // 64-byte block; the sixteenth also pads, runs the second hash and queues
  // the digest that the block must return.
  function automatic void absorb_chunk(input logic [63:0] chunk);
    msg_block_t  blk;
    hash_state_t second;
    digest_t     expect_dig;
    logic [2:0]  slot;
    int i;
    slot = header_pos[2:0];
    block_chunks[slot] = chunk;
    if (slot == 3'd7) begin
      // Header bytes are big-endian words for SHA-256; chunks are little-endian.
      for (i = 0; i < 8; i++) begin
        blk[2*i]   = byte_rev(block_chunks[i][31:0]);
        blk[2*i+1] = byte_rev(block_chunks[i][63:32]);
      end
      chain_hash = sha_compress(chain_hash, blk);
    end
    if (header_pos != 4'd15) begin
      header_pos = header_pos + 4'd1;
      return;
    end
    blk = '0;
    blk[0]  = PAD_MARK;
    blk[15] = HEADER_LEN_BITS;
    chain_hash = sha_compress(chain_hash, blk);
    blk = '0;
    for (i = 0; i < 8; i++) begin
      blk[i] = chain_hash[i];
    end
    blk[8]  = PAD_MARK;
    blk[15] = DIGEST_LEN_BITS;
    second = sha_compress(SHA_IV, blk);
    expect_dig.q3 = {second[0], second[1]};
    expect_dig.q2 = {second[2], second[3]};
    expect_dig.q1 = {second[4], second[5]};
    expect_dig.q0 = {second[6], second[7]};
    pending_digests = {pending_digests, expect_dig};
    chain_hash = SHA_IV;
    header_pos = 4'd0;
  endfunction

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, actual %h", field, want, got);
      fail_count++;
    end
  endfunction

  // -------------------------------------------------------------------------
  // Monitor: both channels are sampled at the rising edge. A digest beat is
  // always for an older header than any chunk taken in the same cycle, so
  // the order of the two branches does not matter.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        absorb_chunk(in_header_chunk);
      end
      if (out_valid && out_ready) begin
        if (pending_digests.size() == 0) begin
          $error("digest beat with no header pending: q3 %h", out_hash_q3);
          fail_count++;
        end else begin
          oldest_digest = pending_digests.pop_front();
          check_field("hash_q0", oldest_digest.q0, out_hash_q0);
          check_field("hash_q1", oldest_digest.q1, out_hash_q1);
          check_field("hash_q2", oldest_digest.q2, out_hash_q2);
          check_field("hash_q3", oldest_digest.q3, out_hash_q3);
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a beat. The
  // longest honest quiet spell is a three-compression header close plus the
  // receiver's longest hold, well under the limit.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("block_header_double_sha256_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: out_ready changes at the falling edge. It runs in stretches of
  // always ready, ready on a coin toss, or held off, at times long enough that the
  // next header finishes and the block must wait on the unread digest.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(2, 0));
      case (ready_mode)
        RDY_OPEN:   ready_left = $urandom_range(200, 20);
        RDY_CHOPPY: ready_left = $urandom_range(100, 20);
        default:    ready_left = $urandom_range(400, 1);
      endcase
    end
    ready_left = ready_left - 1;
    case (ready_mode)
      RDY_OPEN:   out_ready = 1'b1;
      RDY_CHOPPY: out_ready = 1'($urandom_range(1, 0));
      default:    out_ready = 1'b0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Sender
  // -------------------------------------------------------------------------

  // Random chunk content: mostly uniform, with all-zero, all-one, one-hot and
  // one-cold patterns mixed in so every input bit is seen at both values.
  function automatic logic [63:0] random_chunk();
    logic [63:0] one_hot;
    int pick;
    pick = $urandom_range(9, 0);
    one_hot = 64'd1 << $urandom_range(63, 0);
    case (pick)
      0:       return '0;
      1:       return '1;
      2:       return one_hot;
      3:       return ~one_hot;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Called at a falling edge. Between bursts valid may drop for a random gap;
  // inside a burst valid stays high and only the payload changes after each
  // accepted beat. Returns at the falling edge after the beat is taken.
  task automatic send_chunk(input logic [63:0] chunk);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(60, 1);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left = burst_left - 1;
    in_valid = 1'b1;
    in_header_chunk = chunk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int row;
    int n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_header_chunk = '0;
    out_ready = 1'b0;
    ready_left = 0;
    ready_mode = RDY_OPEN;
    burst_left = 0;
    fail_count = 0;
    idle_cycles = 0;
    chain_hash = SHA_IV;
    block_chunks = '0;
    header_pos = 4'd0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: walk the stimulus table.
    for (row = 0; row < DIRECTED_ROWS; row++) begin
      send_chunk(DIRECTED_CHUNKS[row]);
    end

    // Random part: every chunk is a legal part of a header stream; the last four
    // chunks open a header that is never finished, so they are not hashed.
    for (n = 0; n < RANDOM_CHUNKS; n++) begin
      send_chunk(random_chunk());
    end
    in_valid = 1'b0;

    // Let every queued digest come back, then watch for strays.
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("block_header_double_sha256_top regression: pass");
    end else begin
      $display("block_header_double_sha256_top regression: fail");
    end
    $finish;
  end

endmodule
